[rtl/jacobi_rotation_coefficients_defines.svh]
// Assertion macros used by the checker file jrc_checker.sv.
`ifndef JACOBI_ROTATION_COEFFICIENTS_DEFINES_SVH
`define JACOBI_ROTATION_COEFFICIENTS_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define JRC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jrc check failed");

// Next-cycle implication, also checked during reset.
`define JRC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("jrc check failed");

`endif

[rtl/jrc_pkg.sv]
package jrc_pkg;

  localparam int IN_W   = 32;
  localparam int DIFF_W = 33;
  localparam int SQ_W   = 66;
  localparam int N_W    = 66;
  localparam int COS_W  = 31;
  localparam int SIN_W  = 32;

  localparam int LANES    = 2;
  localparam int LANE_COS = 0;
  localparam int LANE_SIN = 1;

  // sideband that travels with every beat through the pipeline
  typedef struct packed {
    logic vld;
    logic zero;
    logic neg;
  } side_t;

  // widths of the search state, from the fraction width
  function automatic int s_w(input int f);
    return f + 4;
  endfunction

  function automatic int p_w(input int f);
    return 2 * f + 5;
  endfunction

  function automatic int t1_w(input int f);
    return N_W + f + 3;
  endfunction

  function automatic int t2_w(input int f);
    return N_W + 2 * f + 5;
  endfunction

  function automatic int t3_w(input int f);
    return N_W + 3 * f + 7;
  endfunction

  function automatic int w_w(input int f);
    return N_W + 4 * f + 10;
  endfunction

endpackage

[rtl/jrc_ifs.sv]
interface jrc_in_if;
  logic                     valid;
  logic                     ready;
  logic signed [31:0]       diag_first;
  logic signed [31:0]       off_diag;
  logic signed [31:0]       diag_second;

  modport source (output valid, diag_first, off_diag, diag_second, input ready);
  modport sink   (input valid, diag_first, off_diag, diag_second, output ready);
endinterface

interface jrc_out_if;
  logic                     valid;
  logic                     ready;
  logic        [30:0]       cosine;
  logic signed [31:0]       sine;

  modport source (output valid, cosine, sine, input ready);
  modport sink   (input valid, cosine, sine, output ready);
endinterface

[rtl/jrc_prep.sv]
module jrc_prep #(
  parameter int FRAC_BITS = 30,
  localparam int SW  = jrc_pkg::s_w(FRAC_BITS),
  localparam int PW  = jrc_pkg::p_w(FRAC_BITS),
  localparam int T1W = jrc_pkg::t1_w(FRAC_BITS),
  localparam int T2W = jrc_pkg::t2_w(FRAC_BITS),
  localparam int T3W = jrc_pkg::t3_w(FRAC_BITS),
  localparam int WW  = jrc_pkg::w_w(FRAC_BITS)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  output logic                          in_rdy,
  input  logic signed [31:0]            in_xii,
  input  logic signed [31:0]            in_xij,
  input  logic signed [31:0]            in_xjj,
  output jrc_pkg::side_t                out_side,
  input  logic                          out_rdy,
  output logic [jrc_pkg::N_W-1:0]       out_n,
  output logic signed [SW-1:0]          out_s  [2],
  output logic [PW-1:0]                 out_p  [2],
  output logic signed [T1W-1:0]         out_t1 [2],
  output logic signed [T2W-1:0]         out_t2 [2],
  output logic signed [T3W-1:0]         out_t3 [2],
  output logic signed [WW-1:0]          out_w  [2]
);

  logic                                 adv_a;
  logic                                 adv_b;
  logic signed [jrc_pkg::DIFF_W-1:0]    d;
  logic [jrc_pkg::DIFF_W-1:0]           a_mag;
  logic [31:0]                          off_mag;
  jrc_pkg::side_t                       side_a_r;
  logic [jrc_pkg::SQ_W-1:0]             a2_r;
  logic [jrc_pkg::SQ_W-1:0]             b2_r;
  jrc_pkg::side_t                       side_b_r;
  logic [jrc_pkg::N_W-1:0]              n_nxt;
  logic signed [WW-1:0]                 nx;
  logic signed [WW-1:0]                 b2x;
  logic signed [WW-1:0]                 w_nxt;
  logic [jrc_pkg::N_W-1:0]              n_r;
  logic signed [WW-1:0]                 w_r;

  // stage handshake: a stage takes a beat when empty or draining
  assign adv_b  = !side_b_r.vld || out_rdy;
  assign adv_a  = !side_a_r.vld || adv_b;
  assign in_rdy = adv_a;

  // difference of the diagonals and magnitudes
  assign d       = {in_xjj[31], in_xjj} - {in_xii[31], in_xii};
  assign a_mag   = d[jrc_pkg::DIFF_W-1] ? jrc_pkg::DIFF_W'(-d) : jrc_pkg::DIFF_W'(d);
  assign off_mag = in_xij[31] ? 32'(-in_xij) : 32'(in_xij);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_a_r <= '0;
    end else if (adv_a) begin
      side_a_r.vld  <= in_vld;
      side_a_r.zero <= (in_xij == 32'sd0);
      side_a_r.neg  <= (d != '0) && (d[jrc_pkg::DIFF_W-1] != in_xij[31]);
    end
  end

  // square both magnitudes; (2|x_ij|)^2 is four times |x_ij|^2
  always_ff @(posedge clk) begin
    if (adv_a) begin
      a2_r <= jrc_pkg::SQ_W'(a_mag) * jrc_pkg::SQ_W'(a_mag);
      b2_r <= (jrc_pkg::SQ_W'(off_mag) * jrc_pkg::SQ_W'(off_mag)) << 2;
    end
  end

  // initial search state for candidate zero
  assign n_nxt = jrc_pkg::N_W'(a2_r + b2_r);
  assign nx    = {{(WW - jrc_pkg::N_W){1'b0}}, n_nxt};
  assign b2x   = {{(WW - jrc_pkg::SQ_W){1'b0}}, b2_r};
  assign w_nxt = nx - (nx <<< (2 * FRAC_BITS + 2)) + (b2x <<< (4 * FRAC_BITS + 2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_b_r <= '0;
    end else if (adv_b) begin
      side_b_r <= side_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_b) begin
      n_r <= n_nxt;
      w_r <= w_nxt;
    end
  end

  assign out_side = side_b_r;
  assign out_n    = n_r;

  // both searches start from the same point
  for (genvar l = 0; l < jrc_pkg::LANES; l++) begin : g_lane
    assign out_s[l]  = -SW'(1);
    assign out_p[l]  = PW'(1);
    assign out_t1[l] = -T1W'(n_r);
    assign out_t2[l] = T2W'(n_r);
    assign out_t3[l] = -T3W'(n_r);
    assign out_w[l]  = w_r;
  end

endmodule

[rtl/jrc_cell.sv]
module jrc_cell #(
  parameter int FRAC_BITS = 30,
  parameter int BIT       = 0,
  localparam int SW  = jrc_pkg::s_w(FRAC_BITS),
  localparam int PW  = jrc_pkg::p_w(FRAC_BITS),
  localparam int T1W = jrc_pkg::t1_w(FRAC_BITS),
  localparam int T2W = jrc_pkg::t2_w(FRAC_BITS),
  localparam int T3W = jrc_pkg::t3_w(FRAC_BITS),
  localparam int WW  = jrc_pkg::w_w(FRAC_BITS)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  jrc_pkg::side_t                in_side,
  output logic                          in_rdy,
  input  logic [jrc_pkg::N_W-1:0]       in_n,
  input  logic signed [SW-1:0]          in_s  [2],
  input  logic [PW-1:0]                 in_p  [2],
  input  logic signed [T1W-1:0]         in_t1 [2],
  input  logic signed [T2W-1:0]         in_t2 [2],
  input  logic signed [T3W-1:0]         in_t3 [2],
  input  logic signed [WW-1:0]          in_w  [2],
  output jrc_pkg::side_t                out_side,
  input  logic                          out_rdy,
  output logic [jrc_pkg::N_W-1:0]       out_n,
  output logic signed [SW-1:0]          out_s  [2],
  output logic [PW-1:0]                 out_p  [2],
  output logic signed [T1W-1:0]         out_t1 [2],
  output logic signed [T2W-1:0]         out_t2 [2],
  output logic signed [T3W-1:0]         out_t3 [2],
  output logic signed [WW-1:0]          out_w  [2]
);

  localparam logic signed [SW-1:0] H_STEP = SW'(1) <<< (BIT + 1);
  localparam logic signed [PW:0]   H_SQ   = (PW + 1)'(1) <<< (2 * BIT + 2);
  localparam logic [PW-1:0]        Q_LIM  = PW'(1) << (2 * FRAC_BITS + 1);

  logic                                 adv;
  jrc_pkg::side_t                       side_r;
  logic [jrc_pkg::N_W-1:0]              n_r;
  logic signed [WW-1:0]                 nx;
  logic signed [SW-1:0]                 s_r  [2];
  logic [PW-1:0]                        p_r  [2];
  logic signed [T1W-1:0]                t1_r [2];
  logic signed [T2W-1:0]                t2_r [2];
  logic signed [T3W-1:0]                t3_r [2];
  logic signed [WW-1:0]                 w_r  [2];
  logic signed [SW-1:0]                 s_nxt  [2];
  logic [PW-1:0]                        p_nxt  [2];
  logic signed [T1W-1:0]                t1_nxt [2];
  logic signed [T2W-1:0]                t2_nxt [2];
  logic signed [T3W-1:0]                t3_nxt [2];
  logic signed [WW-1:0]                 w_nxt  [2];

  assign adv    = !side_r.vld || out_rdy;
  assign in_rdy = adv;
  assign nx     = {{(WW - jrc_pkg::N_W){1'b0}}, in_n};

  // try setting this bit of the candidate in each lane
  for (genvar l = 0; l < jrc_pkg::LANES; l++) begin : g_lane
    logic signed [WW-1:0] t1x;
    logic signed [WW-1:0] t2x;
    logic signed [WW-1:0] t3x;
    logic signed [WW-1:0] t1_try;
    logic signed [WW-1:0] t2_try;
    logic signed [WW-1:0] t3_try;
    logic signed [WW-1:0] w_try;
    logic signed [PW:0]   sx;
    logic signed [PW:0]   p_try;
    logic                 p_le;
    logic                 ok;

    assign t1x = {{(WW - T1W){in_t1[l][T1W-1]}}, in_t1[l]};
    assign t2x = {{(WW - T2W){in_t2[l][T2W-1]}}, in_t2[l]};
    assign t3x = {{(WW - T3W){in_t3[l][T3W-1]}}, in_t3[l]};
    assign sx  = {{(PW + 1 - SW){in_s[l][SW-1]}}, in_s[l]};

    // binomial update of the power sums for s + h
    assign t1_try = t1x + (nx <<< (BIT + 1));
    assign t2_try = t2x + (t1x <<< (BIT + 2)) + (nx <<< (2 * BIT + 2));
    assign t3_try = t3x + (t2x <<< (BIT + 2)) + (t2x <<< (BIT + 1))
                  + (t1x <<< (2 * BIT + 3)) + (t1x <<< (2 * BIT + 2))
                  + (nx <<< (3 * BIT + 3));
    assign w_try  = in_w[l] + (t3x <<< (BIT + 3))
                  + (t2x <<< (2 * BIT + 4)) + (t2x <<< (2 * BIT + 3))
                  + (t1x <<< (3 * BIT + 5)) + (nx <<< (4 * BIT + 4))
                  - (t1x <<< (2 * FRAC_BITS + BIT + 4))
                  - (nx <<< (2 * FRAC_BITS + 2 * BIT + 4));
    assign p_try  = {1'b0, in_p[l]} + (sx <<< (BIT + 2)) + H_SQ;
    assign p_le   = p_try[PW-1:0] <= Q_LIM;

    // cosine bound holds from above, sine bound from below
    if (l == jrc_pkg::LANE_COS) begin : g_cos
      assign ok = p_le || w_try[WW-1] || (w_try == '0);
    end else begin : g_sin
      assign ok = p_le && !w_try[WW-1];
    end

    assign s_nxt[l]  = ok ? in_s[l] + H_STEP : in_s[l];
    assign p_nxt[l]  = ok ? p_try[PW-1:0] : in_p[l];
    assign t1_nxt[l] = ok ? t1_try[T1W-1:0] : in_t1[l];
    assign t2_nxt[l] = ok ? t2_try[T2W-1:0] : in_t2[l];
    assign t3_nxt[l] = ok ? t3_try[T3W-1:0] : in_t3[l];
    assign w_nxt[l]  = ok ? w_try : in_w[l];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= '0;
    end else if (adv) begin
      side_r <= in_side;
    end
  end

  // advance the payload with the beat
  always_ff @(posedge clk) begin
    if (adv) begin
      n_r  <= in_n;
      s_r  <= s_nxt;
      p_r  <= p_nxt;
      t1_r <= t1_nxt;
      t2_r <= t2_nxt;
      t3_r <= t3_nxt;
      w_r  <= w_nxt;
    end
  end

  assign out_side = side_r;
  assign out_n    = n_r;
  assign out_s    = s_r;
  assign out_p    = p_r;
  assign out_t1   = t1_r;
  assign out_t2   = t2_r;
  assign out_t3   = t3_r;
  assign out_w    = w_r;

endmodule

[rtl/jacobi_rotation_coefficients.sv]
// Jacobi rotation for a symmetric 2x2 block: takes x_ii, x_ij, x_jj and returns the
// cosine and sine (Q1.FRAC_BITS, rounded to nearest) of the rotation that zeroes
// x_ij; a zero x_ij gives cosine 1.0 and sine 0. A new beat is taken every cycle
// while the output does not stall. The prep block registers the squares and then
// the initial search state, then a row of FRAC_BITS + 1 cells settles one result
// bit each for cosine and sine by exact shift-and-add comparison, and a final
// register drives the output. Every stage holds its beat when the next one is
// full, so the row absorbs output stalls.
module jacobi_rotation_coefficients #(
  parameter int FRAC_BITS = 30
) (
  input  logic        clk,
  input  logic        rst_n,
  jrc_in_if.sink      in_bus,
  jrc_out_if.source   out_bus
);

  localparam int SW  = jrc_pkg::s_w(FRAC_BITS);
  localparam int PW  = jrc_pkg::p_w(FRAC_BITS);
  localparam int T1W = jrc_pkg::t1_w(FRAC_BITS);
  localparam int T2W = jrc_pkg::t2_w(FRAC_BITS);
  localparam int T3W = jrc_pkg::t3_w(FRAC_BITS);
  localparam int WW  = jrc_pkg::w_w(FRAC_BITS);
  localparam int NST = FRAC_BITS + 2;

  jrc_pkg::side_t                 side_c [NST];
  logic                           rdy_c  [NST];
  logic [jrc_pkg::N_W-1:0]        n_c    [NST];
  logic signed [SW-1:0]           s_c    [NST][2];
  logic [PW-1:0]                  p_c    [NST][2];
  logic signed [T1W-1:0]          t1_c   [NST][2];
  logic signed [T2W-1:0]          t2_c   [NST][2];
  logic signed [T3W-1:0]          t3_c   [NST][2];
  logic signed [WW-1:0]           w_c    [NST][2];

  logic                           out_vld_r;
  logic [jrc_pkg::COS_W-1:0]      cos_r;
  logic [jrc_pkg::SIN_W-1:0]      sin_r;
  logic [SW-1:0]                  cos_m;
  logic [SW-1:0]                  sin_m;
  logic [jrc_pkg::SIN_W-1:0]      sin_mag;
  logic [jrc_pkg::COS_W-1:0]      cos_nxt;
  logic [jrc_pkg::SIN_W-1:0]      sin_nxt;

  jrc_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_bus.valid),
    .in_rdy   (in_bus.ready),
    .in_xii   (in_bus.diag_first),
    .in_xij   (in_bus.off_diag),
    .in_xjj   (in_bus.diag_second),
    .out_side (side_c[0]),
    .out_rdy  (rdy_c[0]),
    .out_n    (n_c[0]),
    .out_s    (s_c[0]),
    .out_p    (p_c[0]),
    .out_t1   (t1_c[0]),
    .out_t2   (t2_c[0]),
    .out_t3   (t3_c[0]),
    .out_w    (w_c[0])
  );

  // one cell per result bit, most significant first
  for (genvar j = 0; j <= FRAC_BITS; j++) begin : g_cell
    jrc_cell #(.FRAC_BITS(FRAC_BITS), .BIT(FRAC_BITS - j)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_side  (side_c[j]),
      .in_rdy   (rdy_c[j]),
      .in_n     (n_c[j]),
      .in_s     (s_c[j]),
      .in_p     (p_c[j]),
      .in_t1    (t1_c[j]),
      .in_t2    (t2_c[j]),
      .in_t3    (t3_c[j]),
      .in_w     (w_c[j]),
      .out_side (side_c[j+1]),
      .out_rdy  (rdy_c[j+1]),
      .out_n    (n_c[j+1]),
      .out_s    (s_c[j+1]),
      .out_p    (p_c[j+1]),
      .out_t1   (t1_c[j+1]),
      .out_t2   (t2_c[j+1]),
      .out_t3   (t3_c[j+1]),
      .out_w    (w_c[j+1])
    );
  end

  assign rdy_c[NST-1] = !out_vld_r || out_bus.ready;

  // candidate m from s = 2m - 1, apply sign and the zero case
  assign cos_m   = SW'(s_c[NST-1][jrc_pkg::LANE_COS] + SW'(1)) >> 1;
  assign sin_m   = SW'(s_c[NST-1][jrc_pkg::LANE_SIN] + SW'(1)) >> 1;
  assign sin_mag = jrc_pkg::SIN_W'(sin_m);
  assign cos_nxt = side_c[NST-1].zero ? (jrc_pkg::COS_W'(1) << FRAC_BITS)
                                      : jrc_pkg::COS_W'(cos_m);
  assign sin_nxt = side_c[NST-1].zero ? '0
                 : (side_c[NST-1].neg ? -sin_mag : sin_mag);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (rdy_c[NST-1]) begin
      out_vld_r <= side_c[NST-1].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_c[NST-1]) begin
      cos_r <= cos_nxt;
      sin_r <= sin_nxt;
    end
  end

  assign out_bus.valid  = out_vld_r;
  assign out_bus.cosine = cos_r;
  assign out_bus.sine   = sin_r;

endmodule

[rtl/jrc_checker.sv]
`include "jacobi_rotation_coefficients_defines.svh"

module jrc_checker #(
  parameter int FRAC_BITS = 30
) (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [30:0]        cosine,
  input logic signed [31:0] sine
);

  localparam logic [30:0]        COS_ONE = 31'(1) << FRAC_BITS;
  localparam logic signed [31:0] SIN_MAX = 32'sd1 <<< FRAC_BITS;

  // cosine never exceeds one
  `JRC_ASSERT_IMPL(a_cos_range, out_valid, cosine <= COS_ONE)
  // sine stays within plus or minus one
  `JRC_ASSERT_IMPL(a_sin_range, out_valid, (sine <= SIN_MAX) && (sine >= -SIN_MAX))
  // reset empties the output register
  `JRC_ASSERT_NEXT(a_rst_idle, !rst_n, !out_valid)
  // a stalled result holds
  `JRC_ASSERT_NEXT(a_out_hold, rst_n && out_valid && !out_ready,
                   !rst_n || (out_valid && $stable(cosine) && $stable(sine)))

endmodule

bind jacobi_rotation_coefficients jrc_checker #(.FRAC_BITS(FRAC_BITS)) u_jrc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .cosine    (out_bus.cosine),
  .sine      (out_bus.sine)
);

[tb/sv/jrc_rotation_checker.sv]
`timescale 1ns / 1ps

// Watch both channels, predict each rotation from the input beat and compare.
module jrc_rotation_checker #(
  parameter int FRAC_BITS = 30
) (
  input  logic clk,
  input  logic rst_n,
  jrc_in_if    in_mon,
  jrc_out_if   out_mon,
  output int   mismatches,
  output int   rotations_pending
);

  typedef struct packed {
    logic        [30:0] cosine;
    logic signed [31:0] sine;
  } rotation_t;

  typedef logic [255:0] wide_t;

  rotation_t expected_rot[$];

  // Exact rounding terms for the current beat
  wide_t norm_sq;
  wide_t scaled_a_sq;
  wide_t q_unit;

  initial begin
    mismatches        = 0;
    rotations_pending = 0;
  end

  task automatic report(input string what, input longint want, input longint got);
    $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
    mismatches++;
  endtask

  // True when candidate m keeps the rounded magnitude at or below the exact value
  function automatic bit magnitude_fits(input bit is_cos, input longint unsigned m);
    wide_t odd_sq;
    wide_t gap;
    if (m == 0) return 1'b1;
    odd_sq = wide_t'(2 * m - 1) * wide_t'(2 * m - 1);
    if (is_cos) begin
      if (odd_sq <= q_unit) return 1'b1;
      gap = odd_sq - q_unit;
      return gap * gap * norm_sq <= scaled_a_sq;
    end else begin
      if (odd_sq > q_unit) return 1'b0;
      gap = q_unit - odd_sq;
      return gap * gap * norm_sq >= scaled_a_sq;
    end
  endfunction

  function automatic longint unsigned round_magnitude(input bit is_cos);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    lo = 0;
    hi = 64'd1 << FRAC_BITS;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      if (magnitude_fits(is_cos, mid)) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic rotation_t rotation_of(input logic signed [31:0] x_ii,
                                            input logic signed [31:0] x_ij,
                                            input logic signed [31:0] x_jj);
    rotation_t        rot;
    logic signed [33:0] diff;
    logic [33:0]      abs_diff;
    logic [33:0]      twice_off;
    longint unsigned  cmag;
    longint unsigned  smag;
    bit               negative;
    if (x_ij == 0) begin
      rot.cosine = 31'(64'd1 << FRAC_BITS);
      rot.sine   = '0;
      return rot;
    end
    diff      = 34'(x_jj) - 34'(x_ii);
    abs_diff  = diff < 0 ? -diff : diff;
    twice_off = x_ij < 0 ? 34'(-34'(x_ij)) << 1 : 34'(x_ij) << 1;
    q_unit      = wide_t'(1) << (2 * FRAC_BITS + 1);
    norm_sq     = wide_t'(abs_diff) * wide_t'(abs_diff)
                + wide_t'(twice_off) * wide_t'(twice_off);
    scaled_a_sq = q_unit * q_unit * wide_t'(abs_diff) * wide_t'(abs_diff);
    cmag = round_magnitude(1'b1);
    smag = round_magnitude(1'b0);
    negative = (diff != 0) && ((diff < 0) != (x_ij < 0));
    rot.cosine = 31'(cmag);
    rot.sine   = negative ? -32'(smag) : 32'(smag);
    return rot;
  endfunction

  // Push on every input beat, pop and compare on every result beat
  always @(posedge clk) begin
    rotation_t want;
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready)
        expected_rot.push_back(rotation_of(in_mon.diag_first, in_mon.off_diag,
                                           in_mon.diag_second));
      if (out_mon.valid && out_mon.ready) begin
        if (expected_rot.size() == 0) begin
          report("unexpected result, cosine", -1, out_mon.cosine);
        end else begin
          want = expected_rot.pop_front();
          if (out_mon.cosine !== want.cosine)
            report("cosine", want.cosine, out_mon.cosine);
          if (out_mon.sine !== want.sine)
            report("sine", want.sine, out_mon.sine);
        end
      end
      rotations_pending <= expected_rot.size();
    end
  end

endmodule

[tb/sv/tb_jacobi_rotation_coefficients.sv]
`timescale 1ns / 1ps

module tb_jacobi_rotation_coefficients;

  localparam int FRAC_BITS = 30;
  localparam int LATENCY   = FRAC_BITS + 4;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   rotations_pending;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   hold_off_cycles;

  jrc_in_if  in_ch();
  jrc_out_if out_ch();

  jacobi_rotation_coefficients #(.FRAC_BITS(FRAC_BITS)) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_ch),
    .out_bus (out_ch)
  );

  jrc_rotation_checker #(.FRAC_BITS(FRAC_BITS)) i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_mon            (in_ch),
    .out_mon           (out_ch),
    .mismatches        (mismatches),
    .rotations_pending (rotations_pending)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: random stalls, or a long hold-off when requested
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_off_cycles--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Offer one beat and hold it until accepted
  task automatic send_beat(input logic [31:0] x_ii, input logic [31:0] x_ij,
                           input logic [31:0] x_jj);
    int gap;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(6, 1);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.diag_first  <= x_ii;
    in_ch.off_diag    <= x_ij;
    in_ch.diag_second <= x_jj;
    forever begin
      @(negedge clk);
      if (in_ch.ready) break;
    end
    @(posedge clk);
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    forever begin
      @(negedge clk);
      if (rotations_pending == 0) break;
    end
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_entry;
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(40)) - 20);
      2: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      3: return 32'($signed($urandom_range(2000000)) - 1000000);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_phase(input int beats, input int idle_pct, input int stall_pct);
    logic [31:0] x_ii;
    logic [31:0] x_ij;
    logic [31:0] x_jj;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (beats) begin
      x_ii = rand_entry();
      x_ij = ($urandom_range(15) == 0) ? 32'h0 : rand_entry();
      case ($urandom_range(7))
        0: x_jj = x_ii;
        1: x_jj = x_ii + 32'($signed($urandom_range(6)) - 3);
        default: x_jj = rand_entry();
      endcase
      send_beat(x_ii, x_ij, x_jj);
    end
  endtask

  initial begin
    #(8 * 400000);
    $display("FAIL jacobi_rotation_coefficients");
    $finish;
  end

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.diag_first  = '0;
    in_ch.off_diag    = '0;
    in_ch.diag_second = '0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    hold_off_cycles   = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero off-diagonal, equal diagonals, sign combinations, extremes
    send_beat(32'd0, 32'd0, 32'd0);
    send_beat(32'h7fff_ffff, 32'd0, 32'h8000_0000);
    send_beat(32'd5, 32'd3, 32'd5);
    send_beat(32'd5, -32'd3, 32'd5);
    send_beat(32'd1, 32'd1, 32'd4);
    send_beat(32'd1, -32'd1, 32'd4);
    send_beat(32'd4, 32'd1, 32'd1);
    send_beat(32'd4, -32'd1, 32'd1);
    send_beat(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    send_beat(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
    send_beat(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    send_beat(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    send_beat(32'h8000_0000, 32'd1, 32'h7fff_ffff);
    send_beat(32'h7fff_ffff, -32'd1, 32'h8000_0000);
    send_beat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_beat(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_beat(32'd0, 32'd1, 32'd0);
    send_beat(32'd0, 32'h7fff_ffff, 32'd1);
    send_beat(32'd3, 32'd2, 32'd0);
    send_beat(32'haaaa_aaaa, 32'h5555_5555, 32'h5555_5555);
    drain();

    random_phase(300, 0, 0);
    random_phase(300, 71, 0);
    random_phase(300, 0, 71);
    random_phase(300, 20, 20);

    // Hold the receiver off long enough to fill the row and stall the input
    @(negedge clk);
    hold_off_cycles = 300;
    random_phase(300, 0, 0);

    drain();
    if (mismatches == 0) begin
      $display("PASS jacobi_rotation_coefficients");
    end else begin
      $display("FAIL jacobi_rotation_coefficients");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/jrc_pkg.sv
rtl/jrc_ifs.sv
rtl/jrc_prep.sv
rtl/jrc_cell.sv
rtl/jacobi_rotation_coefficients.sv
rtl/jrc_checker.sv
tb/sv/jrc_rotation_checker.sv
tb/sv/tb_jacobi_rotation_coefficients.sv
